FILE: sv/irft_pkg.sv
// shared types, constants and frame builder for the ir remote frame transmitter
package irft_pkg;

    localparam int unsigned FrameBits  = 40;
    localparam int unsigned CodeWidth  = 16;
    localparam int unsigned DataWidth  = 12;
    localparam int unsigned CountWidth = 6;
    localparam int unsigned UnitWidth  = 4;

    localparam logic [CodeWidth-1:0]  CodeReset     = 16'h344A;
    localparam logic [UnitWidth-1:0]  LeadMarkUnits = 4'd8;
    localparam logic [UnitWidth-1:0]  LeadSpaceUnits = 4'd4;
    localparam logic [UnitWidth-1:0]  OneSpaceUnits = 4'd3;
    localparam logic [UnitWidth-1:0]  OneUnit       = 4'd1;
    localparam logic [CountWidth-1:0] FrameLen      = 6'd40;

    // register byte addresses
    localparam logic [2:0] AddrCustomerCode = 3'd0;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP       = 3'd5
    } phase_t;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic frame_end;
    } unit_result_t;

    // code, nibble parity, payload and check byte, msb first
    function automatic logic [FrameBits-1:0] build_frame(
        input logic [CodeWidth-1:0] cc,
        input logic [DataWidth-1:0] dat
    );
        logic [3:0] par;
        logic [7:0] chk;
        begin
            par = cc[15:12] ^ cc[11:8] ^ cc[7:4] ^ cc[3:0];
            chk = {par, dat[11:8]} ^ dat[7:0];
            build_frame = {cc, par, dat, chk};
        end
    endfunction

endpackage

FILE: sv/irft_sequencer.sv
// unit sequencer: frame state and per-unit carrier decision
module irft_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic                                start_req,
    input  logic [irft_pkg::DataWidth-1:0]      payload,
    input  logic [irft_pkg::CodeWidth-1:0]      customer_code,
    output irft_pkg::unit_result_t              result
);
    import irft_pkg::*;

    logic [FrameBits-1:0]  frame_bits_reg, frame_bits_next;
    logic [CountWidth-1:0] bits_left_reg, bits_left_next;
    logic [UnitWidth-1:0]  units_left_reg, units_left_next;
    phase_t                phase_reg, phase_next;

    // state registers advance on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bits_reg <= '0;
            bits_left_reg  <= '0;
            units_left_reg <= '0;
            phase_reg      <= PH_IDLE;
        end else if (step) begin
            frame_bits_reg <= frame_bits_next;
            bits_left_reg  <= bits_left_next;
            units_left_reg <= units_left_next;
            phase_reg      <= phase_next;
        end
    end

    // next state and result for one unit
    always_comb begin
        logic [FrameBits-1:0]  fb;
        logic [CountWidth-1:0] bl;
        logic [UnitWidth-1:0]  ul;
        phase_t                ph;
        logic                  idle;

        fb   = frame_bits_reg;
        bl   = bits_left_reg;
        ul   = units_left_reg;
        ph   = phase_reg;
        idle = !(phase_reg inside {PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK,
                                   PH_BIT_SPACE, PH_STOP});

        result = '0;
        if (idle) begin
            ph = PH_IDLE;
            if (start_req) begin
                fb = build_frame(customer_code, payload);
                bl = FrameLen;
                ph = PH_LEAD_MARK;
                ul = LeadMarkUnits;
            end
        end

        if (ph != PH_IDLE) begin
            result.carrier_on = (ph == PH_LEAD_MARK) || (ph == PH_BIT_MARK) ||
                                (ph == PH_STOP);
            result.busy_res   = 1'b1;
            result.frame_end  = (ph == PH_STOP);

            if (ul != '0) begin
                ul = ul - OneUnit;
            end
            if (ul == '0) begin
                case (ph)
                    PH_LEAD_MARK: begin
                        ph = PH_LEAD_SPACE;
                        ul = LeadSpaceUnits;
                    end
                    PH_LEAD_SPACE: begin
                        ph = PH_BIT_MARK;
                        ul = OneUnit;
                    end
                    PH_BIT_MARK: begin
                        ph = PH_BIT_SPACE;
                        ul = fb[FrameBits-1] ? OneSpaceUnits : OneUnit;
                    end
                    PH_BIT_SPACE: begin
                        fb = {fb[FrameBits-2:0], 1'b0};
                        if (bl != '0) begin
                            bl = bl - 6'd1;
                        end
                        ph = (bl == '0) ? PH_STOP : PH_BIT_MARK;
                        ul = OneUnit;
                    end
                    default: begin
                        ph = PH_IDLE;
                        ul = '0;
                        bl = '0;
                        fb = '0;
                    end
                endcase
            end
        end

        frame_bits_next = fb;
        bits_left_next  = bl;
        units_left_next = ul;
        phase_next      = ph;
    end

    // a running phase always has units to go
    a_units_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (units_left_reg != '0))
        else $error("active phase with zero units left");

    // bit count never exceeds the frame length
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= FrameLen)
        else $error("bits left beyond frame length");

    // the stop unit always returns the sequencer to idle
    a_stop_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_STOP) |=> (phase_reg == PH_IDLE))
        else $error("stop unit not followed by idle");

endmodule

FILE: sv/ir_remote_frame_transmitter.sv
// top level: apb register, beat handshake and result register around the sequencer
// result: a result beat is valid in the cycle after its input beat is accepted
// throughput: one input beat per cycle; the single result register lets the
//   next beat in whenever it is empty or being taken in the same cycle
// reset: synchronous active-low aresetn clears the frame state to idle, empties
//   the result register and sets customer_code to 0x344A
module ir_remote_frame_transmitter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_req,
    input  logic [irft_pkg::DataWidth-1:0]      s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_carrier_on,
    output logic                                m_busy_res,
    output logic                                m_frame_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import irft_pkg::*;

    logic [CodeWidth-1:0] customer_code_reg;
    logic                 m_valid_reg;
    unit_result_t         result_reg;
    unit_result_t         unit_result;
    logic                 s_accept;

    assign pready   = 1'b1;
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // configuration register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            customer_code_reg <= CodeReset;
        end else if (psel && penable && pwrite && paddr == AddrCustomerCode) begin
            customer_code_reg <= pwdata[CodeWidth-1:0];
        end
    end

    // configuration readback
    always_comb begin
        prdata = '0;
        if (paddr == AddrCustomerCode) begin
            prdata = {{(32-CodeWidth){1'b0}}, customer_code_reg};
        end
    end

    irft_sequencer u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_accept),
        .start_req     (s_start_req),
        .payload       (s_payload),
        .customer_code (customer_code_reg),
        .result        (unit_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= unit_result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_carrier_on = result_reg.carrier_on;
    assign m_busy_res   = result_reg.busy_res;
    assign m_frame_end  = result_reg.frame_end;

    // carrier and frame end only appear inside a frame
    a_mark_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_carrier_on || m_frame_end)) |-> m_busy_res)
        else $error("mark or frame end outside a frame");

    // frame end is always a mark unit
    a_end_is_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_carrier_on)
        else $error("frame end on a space unit");

    // an accepted beat always shows up as a result next cycle
    a_accept_to_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted beat produced no result");

endmodule
